// File: design/snim_pkg.sv
// Shared definitions for the sorted nearest index matcher.
// Holds command codes, field widths, default parameter values and the queue header type.
// Used by snim_front, snim_back and the top level; depends on nothing.
`timescale 1ns / 1ps

package snim_pkg;

    // Widths fixed by the item and register formats.
    localparam int CMD_W    = 2;
    localparam int ADDR_W   = 12;
    localparam int IDX_W    = 12;
    localparam int MASS_IN_W = 32;
    localparam int LEN_W    = 13;

    // Default values for the top level parameters.
    localparam int AXIS_DEPTH_DEF = 4096;
    localparam int MASS_WIDTH_DEF = 32;

    // Depth of the queue between front and back.
    localparam int QUEUE_DEPTH = 2;

    // Axis length after reset.
    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(4096);

    // Command codes carried in a beat.
    localparam logic [CMD_W-1:0] CMD_WRITE   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RESTART = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY   = 2'd2;

    // Header of a classified operation as it travels through the queue.
    typedef struct packed {
        logic [CMD_W-1:0]  kind;
        logic [ADDR_W-1:0] addr;
    } op_head_t;

endpackage

// File: design/snim_front.sv
// Front part of the matcher: accepts input beats and classifies them.
// Drops unused commands and out-of-range writes, forwards the rest to the queue.
// Depends on snim_pkg.
`timescale 1ns / 1ps

module snim_front #(
    parameter int AXIS_DEPTH = snim_pkg::AXIS_DEPTH_DEF,
    parameter int MASS_WIDTH = snim_pkg::MASS_WIDTH_DEF
) (
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [snim_pkg::CMD_W-1:0]     s_command,
    input  logic [snim_pkg::ADDR_W-1:0]    s_axis_address,
    input  logic [snim_pkg::MASS_IN_W-1:0] s_mass_value,
    output logic                           push_valid,
    input  logic                           push_ready,
    output snim_pkg::op_head_t             push_head,
    output logic [MASS_WIDTH-1:0]          push_mass
);

    localparam int AW = (AXIS_DEPTH > 1) ? $clog2(AXIS_DEPTH) : 1;
    localparam int CW = (AW + 1 > snim_pkg::ADDR_W + 1) ? AW + 1 : snim_pkg::ADDR_W + 1;

    logic addr_ok;
    logic keep;

    // A write only lands when its address falls inside the store.
    assign addr_ok = (CW'(s_axis_address) < CW'(AXIS_DEPTH));

    // Classify the beat: only real work goes on to the back part.
    always_comb begin
        unique case (s_command)
            snim_pkg::CMD_WRITE:   keep = addr_ok;
            snim_pkg::CMD_RESTART: keep = 1'b1;
            snim_pkg::CMD_QUERY:   keep = 1'b1;
            default:               keep = 1'b0;
        endcase
    end

    // Dropped beats are still taken, so the input only waits on a full queue.
    assign s_ready        = push_ready;
    assign push_valid     = s_valid && keep;
    assign push_head.kind = s_command;
    assign push_head.addr = s_axis_address;
    assign push_mass      = MASS_WIDTH'(s_mass_value);

endmodule

// File: design/snim_queue.sv
// Short first-in first-out queue between the front and back parts.
// Carries classified operations as flat words; depends on nothing.
`timescale 1ns / 1ps

module snim_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0]    count_reg, count_next;
    logic             push;
    logic             pop;

    assign in_ready  = (count_reg != NW'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Pointer and fill count updates, wrapping at the depth.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Payload slots need no reset.
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

// File: design/snim_back.sv
// Back part of the matcher: axis memory, scan pointer and the forward walk.
// Executes queued writes, restarts and queries in order and holds the result register.
// Depends on snim_pkg.
`timescale 1ns / 1ps

module snim_back #(
    parameter int AXIS_DEPTH = snim_pkg::AXIS_DEPTH_DEF,
    parameter int MASS_WIDTH = snim_pkg::MASS_WIDTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [snim_pkg::LEN_W-1:0]   axis_length,
    input  logic                         op_valid,
    output logic                         op_ready,
    input  snim_pkg::op_head_t           op_head,
    input  logic [MASS_WIDTH-1:0]        op_mass,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [snim_pkg::IDX_W-1:0]   m_nearest_index,
    output logic                         m_ran_off_end
);

    localparam int AW = (AXIS_DEPTH > 1) ? $clog2(AXIS_DEPTH) : 1;
    localparam int LW = (AW + 1 > snim_pkg::LEN_W) ? AW + 1 : snim_pkg::LEN_W;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_WALK = 1'b1;

    // Axis memory: one write or one registered read per cycle.
    logic [MASS_WIDTH-1:0] axis_mem [AXIS_DEPTH];
    logic [MASS_WIDTH-1:0] rdata_reg;
    logic                  mem_wr;
    logic                  mem_rd;
    logic [AW-1:0]         mem_addr;

    logic                  state_reg, state_next;
    logic [AW-1:0]         ptr_reg, ptr_next;
    logic [AW:0]           k_reg, k_next;
    logic                  first_reg, first_next;
    logic [MASS_WIDTH-1:0] prev_reg, prev_next;
    logic [MASS_WIDTH-1:0] mass_reg, mass_next;
    logic                  out_valid_reg, out_valid_next;
    logic [snim_pkg::IDX_W-1:0] out_index_reg, out_index_next;
    logic                  out_off_reg, out_off_next;

    logic [LW-1:0]         len_raw;
    logic [LW-1:0]         len_v;
    logic [AW:0]           k_inc;
    logic [MASS_WIDTH-1:0] entry_gap;
    logic                  is_query;

    // Effective axis length: zero counts as one, capped at the store depth.
    assign len_raw = (axis_length == '0) ? LW'(1) : LW'(axis_length);
    assign len_v   = (len_raw > LW'(AXIS_DEPTH)) ? LW'(AXIS_DEPTH) : len_raw;

    // Distance from the peak mass to the entry whose data arrives this cycle.
    assign entry_gap = (mass_reg >= rdata_reg) ? mass_reg - rdata_reg : rdata_reg - mass_reg;

    assign k_inc    = k_reg + 1'b1;
    assign is_query = (op_head.kind == snim_pkg::CMD_QUERY);

    // A query is only taken once the result register is free.
    assign op_ready = (state_reg == ST_IDLE) && (!is_query || !out_valid_reg);

    assign m_valid         = out_valid_reg;
    assign m_nearest_index = out_index_reg;
    assign m_ran_off_end   = out_off_reg;

    // Sequencer for writes, restarts and the forward walk.
    always_comb begin
        state_next     = state_reg;
        ptr_next       = ptr_reg;
        k_next         = k_reg;
        first_next     = first_reg;
        prev_next      = prev_reg;
        mass_next      = mass_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_index_next = out_index_reg;
        out_off_next   = out_off_reg;
        mem_wr         = 1'b0;
        mem_rd         = 1'b0;
        mem_addr       = AW'(op_head.addr);

        unique case (state_reg)
            ST_IDLE: begin
                if (op_valid && op_ready) begin
                    unique case (op_head.kind)
                        snim_pkg::CMD_WRITE: begin
                            mem_wr = 1'b1;
                        end
                        snim_pkg::CMD_RESTART: begin
                            ptr_next = AW'(1);
                        end
                        snim_pkg::CMD_QUERY: begin
                            if (LW'(ptr_reg) >= len_v) begin
                                // Pointer already at the axis end: nothing to walk.
                                out_valid_next = 1'b1;
                                out_index_next = snim_pkg::IDX_W'(len_v - 1'b1);
                                out_off_next   = 1'b1;
                            end else begin
                                mem_rd     = 1'b1;
                                mem_addr   = ptr_reg - 1'b1;
                                k_next     = (AW + 1)'(ptr_reg) - 1'b1;
                                first_next = 1'b1;
                                mass_next  = op_mass;
                                state_next = ST_WALK;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_WALK: begin
                // Fetch the following entry while the current one is judged.
                mem_rd   = 1'b1;
                mem_addr = AW'(k_inc);
                k_next   = k_inc;
                if (first_reg) begin
                    prev_next  = entry_gap;
                    first_next = 1'b0;
                end else if (entry_gap > prev_reg) begin
                    out_valid_next = 1'b1;
                    out_index_next = snim_pkg::IDX_W'(k_reg - 1'b1);
                    out_off_next   = 1'b0;
                    ptr_next       = AW'(k_reg);
                    state_next     = ST_IDLE;
                end else begin
                    prev_next = entry_gap;
                    if (LW'(k_inc) >= len_v) begin
                        out_valid_next = 1'b1;
                        out_index_next = snim_pkg::IDX_W'(len_v - 1'b1);
                        out_off_next   = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            ptr_reg       <= AW'(1);
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Walk datapath and result payload.
    always_ff @(posedge aclk) begin
        k_reg         <= k_next;
        first_reg     <= first_next;
        prev_reg      <= prev_next;
        mass_reg      <= mass_next;
        out_index_reg <= out_index_next;
        out_off_reg   <= out_off_next;
    end

    // Axis memory port.
    always_ff @(posedge aclk) begin
        if (mem_wr) begin
            axis_mem[mem_addr] <= op_mass;
        end
        if (mem_rd) begin
            rdata_reg <= axis_mem[mem_addr];
        end
    end

endmodule

// File: design/sorted_nearest_index_matcher.sv
// Top level of the sorted nearest index matcher.
// Holds the axis length register and joins front, queue and back.
// Depends on snim_pkg, snim_front, snim_queue and snim_back.
//
//   Channel  Ports                                              Beat means
//   s_       s_valid s_ready s_command s_axis_address s_mass_value  one command
//   m_       m_valid m_ready m_nearest_index m_ran_off_end          one query answer
//   cfg_     cfg_valid cfg_ready cfg_data                           axis length write
//
// Writes and restarts are each done in the idle state. A query is taken in the idle state,
// which reads the entry before the scan pointer; the walk state then steps forward through
// the axis, since the axis memory gives one registered read per cycle, until the distance
// to the peak mass grows or the axis end is reached. A query starts only once the previous
// answer is taken.
// Reset (aresetn, synchronous, active low) sets the scan pointer to 1, the axis length
// to 4096 and empties the queue; the axis memory is not cleared.
// Input beats wait only on a full queue; a stalled answer holds a waiting query and all queued behind it.
`timescale 1ns / 1ps

module sorted_nearest_index_matcher #(
    parameter int AXIS_DEPTH = snim_pkg::AXIS_DEPTH_DEF,
    parameter int MASS_WIDTH = snim_pkg::MASS_WIDTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [snim_pkg::LEN_W-1:0]     cfg_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [snim_pkg::CMD_W-1:0]     s_command,
    input  logic [snim_pkg::ADDR_W-1:0]    s_axis_address,
    input  logic [snim_pkg::MASS_IN_W-1:0] s_mass_value,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [snim_pkg::IDX_W-1:0]     m_nearest_index,
    output logic                           m_ran_off_end
);

    localparam int HEAD_W  = $bits(snim_pkg::op_head_t);
    localparam int QWORD_W = HEAD_W + MASS_WIDTH;

    logic [snim_pkg::LEN_W-1:0] axis_length_reg;

    logic                  push_valid;
    logic                  push_ready;
    snim_pkg::op_head_t    push_head;
    logic [MASS_WIDTH-1:0] push_mass;
    logic                  pop_valid;
    logic                  pop_ready;
    logic [QWORD_W-1:0]    pop_data;
    snim_pkg::op_head_t    pop_head;
    logic [MASS_WIDTH-1:0] pop_mass;

    // Axis length register, always ready for a write.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            axis_length_reg <= snim_pkg::LEN_RESET;
        end else if (cfg_valid && cfg_ready) begin
            axis_length_reg <= cfg_data;
        end
    end

    snim_front #(
        .AXIS_DEPTH (AXIS_DEPTH),
        .MASS_WIDTH (MASS_WIDTH)
    ) u_front (
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_axis_address (s_axis_address),
        .s_mass_value   (s_mass_value),
        .push_valid     (push_valid),
        .push_ready     (push_ready),
        .push_head      (push_head),
        .push_mass      (push_mass)
    );

    snim_queue #(
        .WIDTH (QWORD_W),
        .DEPTH (snim_pkg::QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_data   ({push_head, push_mass}),
        .out_valid (pop_valid),
        .out_ready (pop_ready),
        .out_data  (pop_data)
    );

    // Split the queue word back into header and mass.
    assign pop_head = pop_data[QWORD_W-1:MASS_WIDTH];
    assign pop_mass = pop_data[MASS_WIDTH-1:0];

    snim_back #(
        .AXIS_DEPTH (AXIS_DEPTH),
        .MASS_WIDTH (MASS_WIDTH)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .axis_length     (axis_length_reg),
        .op_valid        (pop_valid),
        .op_ready        (pop_ready),
        .op_head         (pop_head),
        .op_mass         (pop_mass),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_nearest_index (m_nearest_index),
        .m_ran_off_end   (m_ran_off_end)
    );

endmodule
